// ----- rtl/tbp_pkg.sv -----
// Shared types and constants for the tagged branch predictor.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

    localparam int ADDR_W          = 32;
    localparam int CTR_W           = 2;
    localparam int IDX_LSB         = 3;
    localparam int TABLE_ENTRIES_D = 64;

    // Prediction mode register codes.
    typedef enum logic [1:0] {
        MODE_ALWAYS_NT = 2'd0,
        MODE_ONE_BIT   = 2'd1,
        MODE_TWO_BIT   = 2'd2,
        MODE_STATIC_NT = 2'd3
    } mode_t;

    // One row of the predictor table.
    typedef struct packed {
        logic                 valid;
        logic [CTR_W-1:0]     ctr;
        logic [ADDR_W-1:0]    tag;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/tbp_table.sv -----
// Predictor table: one-write, one-read memory with registered read data,
// a clearing pass after reset, and same-edge write forwarding. Uses tbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbp_table
    import tbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_D,
    localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t                rd_entry,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire entry_t           wr_entry,
    output logic                  clr_busy
);

    entry_t             mem [TABLE_ENTRIES];
    entry_t             rd_data_reg;
    entry_t             byp_data_reg;
    logic               byp_reg;
    logic               clr_active_reg;
    logic [IDX_W-1:0]   clr_idx_reg;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;

    // The clearing pass owns the write port until every row is zeroed.
    always_comb begin
        mem_we    = clr_active_reg || wr_en;
        mem_waddr = clr_active_reg ? clr_idx_reg : wr_idx;
        mem_wdata = clr_active_reg ? '0 : wr_entry;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // A write landing on the same row at the read edge is not seen by the
    // array read, so its data is kept aside and selected instead.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_idx];
            byp_data_reg <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= wr_en && (wr_idx == rd_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end else if (clr_active_reg) begin
            if (clr_idx_reg == IDX_W'(TABLE_ENTRIES - 1)) begin
                clr_active_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    assign rd_entry = byp_reg ? byp_data_reg : rd_data_reg;
    assign clr_busy = clr_active_reg;

endmodule

`default_nettype wire

// ----- rtl/tagged_branch_predictor_top.sv -----
// Top level of the tagged branch predictor: index pipeline, prediction and
// training logic, result register. Uses tbp_pkg and tbp_table.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on the s_ side is one resolved branch; each transfer on the
// m_ side is its prediction (made from the table row before training), the
// tag hit flag and the mispredict flag, in order. The block takes one branch
// per clock cycle while the result side does not stall; m_tvalid for a result
// rises once its input has passed the input, index, table read and result
// registers, the throughput being set by the single read and single write
// per cycle on the table. After reset a clearing pass zeroes the table one
// row per cycle, during which s_tready is low. Branches that hit the same row
// back to back are forwarded, so no stall ever comes from the table.
// Write cfg_wdata with cfg_we only while no branch is in flight.
module tagged_branch_predictor_top
    import tbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_D
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] branch_address, [32] branch outcome (1 taken), [39:33] zero
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] predicted_taken, [1] tag_hit, [2] mispredicted, [7:3] zero
    output logic [7:0]       m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int WORD_W = ADDR_W - IDX_LSB;

    mode_t               mode_reg;

    logic                a_valid_reg;
    logic [ADDR_W-1:0]   a_addr_reg;
    logic                a_taken_reg;
    logic [IDX_W-1:0]    a_idx;

    logic                b_valid_reg;
    logic [ADDR_W-1:0]   b_addr_reg;
    logic                b_taken_reg;
    logic [IDX_W-1:0]    b_idx_reg;

    logic                c_valid_reg;
    logic [ADDR_W-1:0]   c_addr_reg;
    logic                c_taken_reg;
    logic [IDX_W-1:0]    c_idx_reg;

    logic                m_valid_reg;
    logic [2:0]          m_flags_reg;

    logic                s_accept;
    logic                m_free;
    logic                c_adv;
    logic                b_adv;
    logic                a_adv;
    logic                clr_busy;

    entry_t              cur_entry;
    entry_t              new_entry;
    logic                hit;
    logic                pred;
    logic [CTR_W-1:0]    base_ctr;
    logic [CTR_W:0]      inc_ctr;
    logic [CTR_W:0]      limit;
    logic [CTR_W-1:0]    ctr_next;

    // Handshake chain: a stage moves on when the one after it has room.
    always_comb begin
        m_free   = !m_valid_reg || m_tready;
        c_adv    = c_valid_reg && m_free;
        b_adv    = b_valid_reg && (!c_valid_reg || c_adv);
        a_adv    = a_valid_reg && (!b_valid_reg || b_adv);
        s_tready = !clr_busy && (!a_valid_reg || a_adv);
        s_accept = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ALWAYS_NT;
        end else if (cfg_we) begin
            mode_reg <= mode_t'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept || a_adv) begin
                a_valid_reg <= s_accept;
            end
            if (a_adv || b_adv) begin
                b_valid_reg <= a_adv;
            end
            if (b_adv || c_adv) begin
                c_valid_reg <= b_adv;
            end
            if (c_adv || m_free) begin
                m_valid_reg <= c_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_addr_reg  <= s_tdata[ADDR_W-1:0];
            a_taken_reg <= s_tdata[ADDR_W];
        end
        if (a_adv) begin
            b_addr_reg  <= a_addr_reg;
            b_taken_reg <= a_taken_reg;
            b_idx_reg   <= a_idx;
        end
        if (b_adv) begin
            c_addr_reg  <= b_addr_reg;
            c_taken_reg <= b_taken_reg;
            c_idx_reg   <= b_idx_reg;
        end
        if (c_adv) begin
            m_flags_reg <= {pred != c_taken_reg, hit, pred};
        end
    end

    // Row index is the word address modulo the table size.
    generate
        if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_pow2
            assign a_idx = a_addr_reg[IDX_LSB +: IDX_W];
        end else begin : g_recip
            // Exact floor division by a rounded-up reciprocal: the error of
            // the reciprocal times the largest word stays below one.
            localparam int SHIFT = WORD_W + IDX_W;
            localparam logic [63:0] RECIP =
                ((64'd1 << SHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
            localparam int RECIP_W = WORD_W + 2;

            logic [WORD_W+RECIP_W-1:0] prod_reg;
            logic [WORD_W+RECIP_W-1:0] prod_shifted;
            logic [WORD_W-1:0]         quot;
            logic [WORD_W-1:0]         rem;

            always_ff @(posedge aclk) begin
                if (s_accept) begin
                    prod_reg <= (WORD_W + RECIP_W)'(s_tdata[ADDR_W-1:IDX_LSB])
                              * (WORD_W + RECIP_W)'(RECIP[RECIP_W-1:0]);
                end
            end

            always_comb begin
                prod_shifted = prod_reg >> SHIFT;
                quot         = prod_shifted[WORD_W-1:0];
                rem          = a_addr_reg[ADDR_W-1:IDX_LSB]
                             - WORD_W'(quot * WORD_W'(TABLE_ENTRIES));
            end

            assign a_idx = rem[IDX_W-1:0];
        end
    endgenerate

    tbp_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (b_adv),
        .rd_idx   (b_idx_reg),
        .rd_entry (cur_entry),
        .wr_en    (c_adv),
        .wr_idx   (c_idx_reg),
        .wr_entry (new_entry),
        .clr_busy (clr_busy)
    );

    // Predict from the row as it stands, then train it with the outcome.
    always_comb begin
        hit  = cur_entry.valid && (cur_entry.tag == c_addr_reg);
        pred = 1'b0;
        if (hit) begin
            unique case (mode_reg)
                MODE_ONE_BIT:   pred = (cur_entry.ctr != '0);
                MODE_TWO_BIT:   pred = cur_entry.ctr[1];
                MODE_ALWAYS_NT,
                MODE_STATIC_NT: pred = 1'b0;
                default:        pred = 1'b0;
            endcase
        end

        base_ctr = hit ? cur_entry.ctr : '0;
        inc_ctr  = {1'b0, base_ctr} + 1'b1;
        limit    = (mode_reg == MODE_ONE_BIT) ? (CTR_W+1)'(1) : (CTR_W+1)'(3);

        if (c_taken_reg) begin
            ctr_next = (inc_ctr > limit) ? limit[CTR_W-1:0] : inc_ctr[CTR_W-1:0];
        end else begin
            ctr_next = (base_ctr == '0) ? '0 : base_ctr - 1'b1;
        end

        new_entry.valid = 1'b1;
        new_entry.ctr   = ctr_next;
        new_entry.tag   = c_addr_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_flags_reg};

    // The clearing pass starts at every reset and blocks input while it runs.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted right after reset, before the table was cleared");

    a_no_input_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("input ready while the table clearing pass is running");

    a_no_update_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !c_adv)
        else $error("table training write collides with the clearing pass");

    a_taken_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("taken prediction reported for a missing entry");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for tagged_branch_predictor_top: directed and random
// resolved branches, checked against a behavioral table model. Uses tbp_pkg.
`timescale 1ns / 1ps

module tb_top;
    import tbp_pkg::*;

    localparam int RESULT_LATENCY = 4;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int POOL_SIZE      = 16;

    typedef struct packed {
        logic predicted_taken;
        logic tag_hit;
        logic mispredicted;
    } branch_outcome_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_wdata = '0;

    // Shadow copy of the predictor table and mode register.
    logic [ADDR_W-1:0] shadow_tag   [TABLE_ENTRIES_D];
    logic [CTR_W-1:0]  shadow_ctr   [TABLE_ENTRIES_D];
    logic              shadow_valid [TABLE_ENTRIES_D];
    mode_t             shadow_mode;

    branch_outcome_t   expected_outcomes[$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    int unsigned       taken_bias [POOL_SIZE];

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned hold_len     = 0;
    int unsigned hold_seq     = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;
    int unsigned error_count  = 0;
    int unsigned sent_count   = 0;
    int unsigned result_count = 0;
    int unsigned hit_count    = 0;
    int unsigned mode_writes  = 0;

    tagged_branch_predictor_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side ready. A requested hold-off is counted here so that it runs
    // independently of the sending side.
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic branch_outcome_t predict_branch(input logic [ADDR_W-1:0] addr,
                                                        input logic taken);
        int unsigned     row;
        int unsigned     ctr;
        int unsigned     ceiling;
        branch_outcome_t res;
        row = (addr >> IDX_LSB) % TABLE_ENTRIES_D;
        res.tag_hit = shadow_valid[row] && (shadow_tag[row] == addr);
        ctr = shadow_ctr[row];
        res.predicted_taken = 1'b0;
        if (res.tag_hit && shadow_mode == MODE_ONE_BIT) begin
            res.predicted_taken = (ctr > 0);
        end else if (res.tag_hit && shadow_mode == MODE_TWO_BIT) begin
            res.predicted_taken = (ctr > 1);
        end
        // A miss claims the row with a fresh counter before training.
        if (!res.tag_hit) begin
            shadow_tag[row]   = addr;
            shadow_valid[row] = 1'b1;
            ctr = 0;
        end
        if (taken) begin
            ceiling = (shadow_mode == MODE_ONE_BIT) ? 1 : 3;
            ctr = (ctr + 1 > ceiling) ? ceiling : ctr + 1;
        end else if (ctr > 0) begin
            ctr--;
        end
        shadow_ctr[row] = CTR_W'(ctr);
        res.mispredicted = (res.predicted_taken != taken);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : check_results
        branch_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (m_tdata[1] === 1'b1) begin
                hit_count++;
            end
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %b",
                         $time, m_tdata[2:0]);
                error_count++;
            end else begin
                want = expected_outcomes.pop_front();
                check_field("predicted_taken", want.predicted_taken, m_tdata[0]);
                check_field("tag_hit", want.tag_hit, m_tdata[1]);
                check_field("mispredicted", want.mispredicted, m_tdata[2]);
            end
        end
    end

    // Offers one branch and returns at the edge of its transfer. A sender gap,
    // when drawn, lowers tvalid in the step of the previous transfer.
    task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, taken, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_outcomes.push_back(predict_branch(addr, taken));
        sent_count++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY) @(posedge aclk);
    endtask

    // Called only with nothing in flight.
    task automatic write_mode(input mode_t mode);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
        shadow_mode = mode;
        mode_writes++;
    endtask

    // Invalid rows must miss, even for an all-zero address against cleared rows.
    task automatic test_reset_state();
        send_branch('1, 1'b1);
        send_branch('1, 1'b1);
        send_branch('0, 1'b0);
        send_branch('0, 1'b0);
        wait_results_done();
    endtask

    // One-bit mode: saturation at one, floor at zero, and replacement of a row by
    // an address with the same index but another tag.
    task automatic test_one_bit();
        write_mode(MODE_ONE_BIT);
        send_branch(32'h0000_0010, 1'b1);
        send_branch(32'h0000_0010, 1'b1);
        send_branch(32'h0000_0010, 1'b0);
        send_branch(32'h0000_0010, 1'b0);
        send_branch(32'h0000_0210, 1'b1);
        send_branch(32'h0000_0010, 1'b1);
        wait_results_done();
    endtask

    task automatic test_two_bit();
        write_mode(MODE_TWO_BIT);
        repeat (4) send_branch(32'h7FFF_FFF8, 1'b1);
        wait_results_done();
    endtask

    // Counters survive mode changes; a saturated two-bit counter is clamped by a
    // taken branch in one-bit mode, and static mode trains without predicting.
    task automatic test_mode_switch();
        write_mode(MODE_ONE_BIT);
        send_branch(32'h7FFF_FFF8, 1'b1);
        send_branch(32'h7FFF_FFF8, 1'b0);
        wait_results_done();
        write_mode(MODE_STATIC_NT);
        repeat (3) send_branch(32'h7FFF_FFF8, 1'b1);
        wait_results_done();
        write_mode(MODE_TWO_BIT);
        send_branch(32'h7FFF_FFF8, 1'b0);
        wait_results_done();
        write_mode(MODE_ALWAYS_NT);
        send_branch(32'h5555_5555, 1'b1);
        send_branch(32'hAAAA_AAAA, 1'b0);
        wait_results_done();
    endtask

    // Mostly a small set of hot branches, half of them aliasing the other half
    // on the table row, with random addresses mixed in as noise.
    task automatic test_random_traffic(input int unsigned count, input int unsigned src_pct,
                                       input int unsigned snk_pct);
        int unsigned      i;
        int unsigned      pick;
        int unsigned      until_mode_change;
        logic [ADDR_W-1:0] addr;
        logic             taken;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (i = 0; i < POOL_SIZE / 2; i++) begin
            addr_pool[i] = $urandom;
            addr_pool[i + POOL_SIZE / 2] = addr_pool[i] ^ ($urandom_range(1, 8388607) << 9);
        end
        for (i = 0; i < POOL_SIZE; i++) begin
            taken_bias[i] = $urandom_range(5, 95);
        end
        until_mode_change = $urandom_range(30, 60);
        for (i = 0; i < count; i++) begin
            if (until_mode_change == 0) begin
                wait_results_done();
                write_mode(mode_t'(2'($urandom_range(0, 3))));
                until_mode_change = $urandom_range(30, 60);
            end
            until_mode_change--;
            pick = $urandom_range(99);
            if (pick < 84) begin
                pick  = $urandom_range(POOL_SIZE - 1);
                addr  = addr_pool[pick];
                taken = ($urandom_range(99) < taken_bias[pick]);
            end else begin
                addr  = (pick < 96) ? $urandom : ((pick < 98) ? '0 : '1);
                taken = 1'($urandom_range(1));
            end
            send_branch(addr, taken);
        end
        wait_results_done();
    endtask

    // The result side stalls long enough for the block to fill and stall its
    // input; afterwards the sender pauses until everything has drained.
    task automatic test_backpressure();
        int unsigned       i;
        logic [ADDR_W-1:0] addr;
        write_mode(MODE_TWO_BIT);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_len <= 300;
        hold_seq <= hold_seq + 1;
        // Every address lands on row 9 with a few different tags.
        for (i = 0; i < 40; i++) begin
            addr = {1'($urandom_range(1)), 17'd0, 2'($urandom_range(3)),
                    3'($urandom_range(7)), 6'd9, 3'($urandom)};
            send_branch(addr, 1'($urandom_range(1)));
        end
        wait_results_done();
        for (i = 0; i < 20; i++) begin
            send_branch(32'h0000_0048 | (($urandom_range(1)) << 20), 1'($urandom_range(1)));
        end
        wait_results_done();
    endtask

    initial begin
        for (int r = 0; r < TABLE_ENTRIES_D; r++) begin
            shadow_tag[r]   = '0;
            shadow_ctr[r]   = '0;
            shadow_valid[r] = 1'b0;
        end
        shadow_mode = MODE_ALWAYS_NT;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_one_bit();
        test_two_bit();
        test_mode_switch();
        test_backpressure();
        write_mode(MODE_STATIC_NT);
        test_random_traffic(110, 6, 68);
        test_random_traffic(110, 68, 6);
        test_random_traffic(110, 0, 0);
        write_mode(MODE_ONE_BIT);
        test_random_traffic(40, 0, 0);

        repeat (RESULT_LATENCY * 4) @(posedge aclk);
        if (expected_outcomes.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_outcomes.size());
            error_count++;
        end
        $display("Sent %0d branches over %0d mode writes; checked %0d results, %0d tag hits.",
                 sent_count, mode_writes, result_count, hit_count);
        $display("Covered all four modes, row aliasing, saturation and long output stalls.");
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
